// ===== design/csv_field_tokenizer_top_assert.svh =====
`ifndef CSV_FIELD_TOKENIZER_TOP_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define CSVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csv tokenizer check failed");

// next-cycle implication
`define CSVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csv tokenizer check failed");

`endif

// ===== design/csvtok_pkg.sv =====
package csvtok_pkg;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned MODE_W   = 2;

    localparam logic [LEN_W-1:0] MAX_VALUE_LENGTH = 16'hFFFF;
    localparam logic [IDX_W-1:0] MAX_FIELDS       = 9'd256;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned CNT_W      = 3;

    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QOPEN  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUOTED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_VALUE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REC_OK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REC_BAD  = 2'd2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic [IDX_W-1:0]  index;
        logic              is_last;
    } csvtok_result_t;

    function automatic csvtok_result_t csvtok_make(
        input logic [KIND_W-1:0] kind,
        input logic [POS_W-1:0]  start,
        input logic [LEN_W-1:0]  length,
        input logic [IDX_W-1:0]  index
    );
        csvtok_result_t r;
        r.kind    = kind;
        r.start   = start;
        r.length  = length;
        r.index   = index;
        r.is_last = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/csv_field_tokenizer_top.sv =====
// CSV field tokenizer: takes one byte of CSV text per beat on the s_ stream and
// reports each non-empty value (start offset, length, index in record) and each
// record end (value count, checked against expected_fields) on the m_ stream.
// A byte is taken every cycle while the queue holds two results or fewer; a byte
// that closes an unquoted value and the record together yields two result beats.
// Results pass through a four-entry output queue, so sustained rate is one byte
// per cycle as long as m_tready is high and results average at most one per byte.
// s_tlast flushes any open value and returns the scanner to its reset state.
`include "csv_field_tokenizer_top_assert.svh"

module csv_field_tokenizer_top
    import csvtok_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,   // expected_fields

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // end_of_input

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // [31:0] value_start, [47:32] value_length,
                                       // [56:48] field_index, [63:57] zero
    output logic [1:0]  m_tuser,       // [1:0] token_kind
    output logic        m_tlast        // last_result
);

    logic [IDX_W-1:0]  expected_reg;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [IDX_W-1:0]  vir_reg, vir_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    csvtok_result_t    fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    csvtok_result_t    res0, res1;
    logic [1:0]        n_res;
    logic              in_fire, out_fire;
    logic              is_blank, is_eol;
    logic [LEN_W-1:0]  len_inc;
    logic [IDX_W-1:0]  vir_inc;
    logic [7:0]        ch;

    assign ch       = s_tdata;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_VT);
    assign is_eol   = (ch == CH_LF) || (ch == CH_NUL);
    assign len_inc  = (len_reg < MAX_VALUE_LENGTH) ? len_reg + LEN_W'(1) : len_reg;
    assign vir_inc  = (vir_reg < MAX_FIELDS) ? vir_reg + IDX_W'(1) : vir_reg;

    always_comb begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        start_next = start_reg;
        vir_next   = vir_reg;
        n_res      = 2'd0;
        res0       = '0;
        res1       = '0;

        unique case (mode_reg)
            MODE_IDLE, MODE_QOPEN: begin
                priority if (is_blank) begin
                end else if (ch == CH_COMMA) begin
                    mode_next = MODE_IDLE;
                end else if (is_eol) begin
                    res0 = csvtok_make((vir_reg == expected_reg) ? KIND_REC_OK : KIND_REC_BAD,
                                       pos_reg, '0, vir_reg);
                    n_res     = 2'd1;
                    vir_next  = '0;
                    mode_next = MODE_IDLE;
                end else if (ch == CH_QUOTE) begin
                    mode_next = MODE_QOPEN;
                end else begin
                    mode_next  = (mode_reg == MODE_QOPEN) ? MODE_QUOTED : MODE_PLAIN;
                    start_next = pos_reg;
                    len_next   = LEN_W'(1);
                end
            end
            MODE_PLAIN: begin
                priority if (ch == CH_COMMA || is_eol) begin
                    res0      = csvtok_make(KIND_VALUE, start_reg, len_reg, vir_reg);
                    n_res     = 2'd1;
                    vir_next  = vir_inc;
                    len_next  = '0;
                    mode_next = MODE_IDLE;
                    if (is_eol) begin
                        res1 = csvtok_make((vir_inc == expected_reg) ? KIND_REC_OK
                                                                     : KIND_REC_BAD,
                                           pos_reg, '0, vir_inc);
                        n_res    = 2'd2;
                        vir_next = '0;
                    end
                end else begin
                    len_next = len_inc;
                end
            end
            MODE_QUOTED: begin
                priority if (ch == CH_QUOTE) begin
                    res0      = csvtok_make(KIND_VALUE, start_reg, len_reg, vir_reg);
                    n_res     = 2'd1;
                    vir_next  = vir_inc;
                    len_next  = '0;
                    mode_next = MODE_IDLE;
                end else begin
                    len_next = len_inc;
                end
            end
            default: begin
            end
        endcase

        pos_next = pos_reg + POS_W'(1);

        if (s_tlast) begin
            if (mode_next == MODE_PLAIN || mode_next == MODE_QUOTED) begin
                res0  = csvtok_make(KIND_VALUE, start_next, len_next, vir_next);
                n_res = 2'd1;
            end
            mode_next  = MODE_IDLE;
            len_next   = '0;
            start_next = '0;
            vir_next   = '0;
            pos_next   = '0;
        end

        if (n_res == 2'd1) begin
            res0.is_last = 1'b1;
        end
        if (n_res == 2'd2) begin
            res1.is_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= IDX_W'(1);
        end else if (cfg_wr_en) begin
            expected_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            len_reg   <= '0;
            start_reg <= '0;
            vir_reg   <= '0;
            pos_reg   <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            vir_reg   <= vir_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && n_res != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (in_fire && n_res == 2'd2) begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_fire) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (out_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (in_fire ? CNT_W'(n_res) : CNT_W'(0))
                                   - (out_fire ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {7'd0, fifo_mem[rd_ptr_reg].index, fifo_mem[rd_ptr_reg].length,
                       fifo_mem[rd_ptr_reg].start};
    assign m_tuser  = fifo_mem[rd_ptr_reg].kind;
    assign m_tlast  = fifo_mem[rd_ptr_reg].is_last;

    `CSVT_ASSERT_NOW(a_len_idle_zero, aclk, aresetn,
        (mode_reg == MODE_IDLE || mode_reg == MODE_QOPEN), (len_reg == '0))
    `CSVT_ASSERT_NOW(a_len_open_nonzero, aclk, aresetn,
        (mode_reg == MODE_PLAIN || mode_reg == MODE_QUOTED), (len_reg != '0))
    `CSVT_ASSERT_NEXT(a_flush_resets, aclk, aresetn,
        (in_fire && s_tlast), (pos_reg == '0 && mode_reg == MODE_IDLE && vir_reg == '0))
    `CSVT_ASSERT_NEXT(a_pos_advance, aclk, aresetn,
        (in_fire && !s_tlast), (pos_reg == $past(pos_reg) + POS_W'(1)))
    `CSVT_ASSERT_NEXT(a_pair_queued, aclk, aresetn,
        (in_fire && n_res == 2'd2), (count_reg >= CNT_W'(2)))

endmodule

// ===== tb/tb_top.sv =====
module tb_top
    import csvtok_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RX_HOLD_CYCLES = 90;
    localparam int TAIL_CYCLES    = 24;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        int         listed;     // -1: predicted, else count of listed tokens
    } csv_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;       // [7:0] data_byte
    logic        s_tlast;       // end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;       // [31:0] value_start, [47:32] value_length,
                                // [56:48] field_index, [63:57] zero
    logic [1:0]  m_tuser;       // [1:0] token_kind
    logic        m_tlast;       // last_result

    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold_req;
    int mismatches;
    int bytes_fed;

    csvtok_result_t tokens_due[$];

    // scanner state as the block should hold it
    logic [1:0]  sc_mode;
    logic [15:0] sc_len;
    logic [31:0] sc_start;
    logic [31:0] sc_pos;
    logic [8:0]  sc_count;
    logic [8:0]  sc_expected;

    csvtok_result_t scan_out[2];
    int             scan_n;

    csv_row_t opening_rows[26] = '{
        '{CH_LF,    1'b0,  1},
        '{8'h61,    1'b0,  0},
        '{CH_LF,    1'b0,  2},
        '{CH_SPACE, 1'b0, -1},
        '{CH_QUOTE, 1'b0, -1},
        '{CH_TAB,   1'b0, -1},
        '{CH_QUOTE, 1'b0, -1},
        '{CH_COMMA, 1'b0, -1},
        '{CH_QUOTE, 1'b0, -1},
        '{8'h78,    1'b0, -1},
        '{CH_LF,    1'b0, -1},
        '{CH_COMMA, 1'b0, -1},
        '{CH_NUL,   1'b0, -1},
        '{CH_QUOTE, 1'b0, -1},
        '{8'h79,    1'b0, -1},
        '{8'hFF,    1'b0, -1},
        '{CH_COMMA, 1'b0, -1},
        '{CH_VT,    1'b0, -1},
        '{CH_COMMA, 1'b0, -1},
        '{CH_QUOTE, 1'b0, -1},
        '{CH_QUOTE, 1'b0, -1},
        '{CH_CR,    1'b0, -1},
        '{CH_NUL,   1'b0, -1},
        '{8'h7A,    1'b0, -1},
        '{8'h80,    1'b1,  1},
        '{CH_QUOTE, 1'b1,  0}
    };

    csvtok_result_t opening_tokens[4] = '{
        '{KIND_REC_BAD, 32'd0,  16'd0, 9'd0, 1'b1},
        '{KIND_VALUE,   32'd1,  16'd1, 9'd0, 1'b0},
        '{KIND_REC_OK,  32'd2,  16'd0, 9'd1, 1'b1},
        '{KIND_VALUE,   32'd23, 16'd2, 9'd0, 1'b1}
    };

    csv_field_tokenizer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void clear_scan();
        sc_mode  = MODE_IDLE;
        sc_len   = '0;
        sc_start = '0;
        sc_pos   = '0;
        sc_count = '0;
    endfunction

    function automatic void put_token(logic [1:0] kind, logic [31:0] start,
                                      logic [15:0] len, logic [8:0] idx);
        csvtok_result_t t;
        t.kind    = kind;
        t.start   = start;
        t.length  = len;
        t.index   = idx;
        t.is_last = 1'b0;
        scan_out[scan_n] = t;
        scan_n++;
    endfunction

    function automatic void close_value();
        put_token(KIND_VALUE, sc_start, sc_len, sc_count);
        if (sc_count < MAX_FIELDS)
            sc_count++;
        sc_len  = '0;
        sc_mode = MODE_IDLE;
    endfunction

    function automatic void close_record(logic [31:0] at);
        put_token((sc_count == sc_expected) ? KIND_REC_OK : KIND_REC_BAD, at, 16'd0, sc_count);
        sc_count = '0;
        sc_mode  = MODE_IDLE;
    endfunction

    function automatic void grow_value();
        if (sc_len < MAX_VALUE_LENGTH)
            sc_len++;
    endfunction

    function automatic int scan_byte(logic [7:0] b, logic eoi);
        logic [31:0] at;
        logic        blank;
        logic        eol;
        at     = sc_pos;
        scan_n = 0;
        blank  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_VT);
        eol    = (b == CH_LF) || (b == CH_NUL);
        case (sc_mode)
            MODE_IDLE, MODE_QOPEN: begin
                if (!blank) begin
                    if (b == CH_COMMA)
                        sc_mode = MODE_IDLE;
                    else if (eol)
                        close_record(at);
                    else if (b == CH_QUOTE)
                        sc_mode = MODE_QOPEN;
                    else begin
                        sc_mode  = (sc_mode == MODE_QOPEN) ? MODE_QUOTED : MODE_PLAIN;
                        sc_start = at;
                        sc_len   = 16'd1;
                    end
                end
            end
            MODE_PLAIN: begin
                if (b == CH_COMMA)
                    close_value();
                else if (eol) begin
                    close_value();
                    close_record(at);
                end else
                    grow_value();
            end
            default: begin
                if (b == CH_QUOTE)
                    close_value();
                else
                    grow_value();
            end
        endcase
        sc_pos = at + 32'd1;
        if (eoi) begin
            if (sc_mode == MODE_PLAIN || sc_mode == MODE_QUOTED)
                close_value();
            clear_scan();
        end
        if (scan_n > 0)
            scan_out[scan_n - 1].is_last = 1'b1;
        return scan_n;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        csvtok_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tokens_due.size() == 0)
                report_mismatch("result beat with nothing due", m_tdata, 64'd0);
            else begin
                want = tokens_due.pop_front();
                compare_field("token_kind",   64'(m_tuser),        64'(want.kind));
                compare_field("value_start",  64'(m_tdata[31:0]),  64'(want.start));
                compare_field("value_length", 64'(m_tdata[47:32]), 64'(want.length));
                compare_field("field_index",  64'(m_tdata[56:48]), 64'(want.index));
                compare_field("tdata pad",    64'(m_tdata[63:57]), 64'd0);
                compare_field("last_result",  64'(m_tlast),        64'(want.is_last));
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic offer_byte(logic [7:0] b, logic eoi);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic feed(logic [7:0] b, logic eoi);
        int n;
        n = scan_byte(b, eoi);
        for (int i = 0; i < n; i++)
            tokens_due.push_back(scan_out[i]);
        offer_byte(b, eoi);
        bytes_fed++;
    endtask

    task automatic await_drain();
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_expected_fields(logic [8:0] v);
        await_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sc_expected = v;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_VT;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_COMMA || b == CH_QUOTE || b == CH_LF || b == CH_NUL);
        return b;
    endfunction

    function automatic logic [7:0] pick_quoted();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    function automatic logic rand_eoi();
        return $urandom_range(199) == 0;
    endfunction

    task automatic feed_record();
        int fields;
        int len;
        int style;
        if (sc_expected >= 1 && sc_expected <= 6)
            fields = int'(sc_expected);
        else
            fields = $urandom_range(0, 4);
        if ($urandom_range(3) == 0)
            fields = $urandom_range(0, 7);
        for (int f = 0; f < fields; f++) begin
            if ($urandom_range(3) == 0)
                feed(pick_blank(), rand_eoi());
            len   = $urandom_range(0, 5);
            style = $urandom_range(0, 19);
            if (style <= 5) begin
                feed(CH_QUOTE, rand_eoi());
                if ($urandom_range(4) == 0)
                    feed(pick_blank(), rand_eoi());
                for (int i = 0; i < len; i++)
                    feed(pick_quoted(), rand_eoi());
                // leave the quote open now and then
                if (style != 0)
                    feed(CH_QUOTE, rand_eoi());
                if (style != 0 && $urandom_range(5) == 0)
                    feed(pick_plain(), rand_eoi());
            end else if (style <= 7) begin
                for (int i = 0; i < len; i++)
                    feed(8'($urandom_range(255)), rand_eoi());
            end else begin
                for (int i = 0; i < len; i++)
                    feed(pick_plain(), rand_eoi());
            end
            if (f < fields - 1)
                feed(CH_COMMA, rand_eoi());
        end
        feed(($urandom_range(3) == 0) ? CH_NUL : CH_LF, rand_eoi());
    endtask

    task automatic run_records(int count);
        int goal;
        goal = bytes_fed + count;
        while (bytes_fed < goal)
            feed_record();
    endtask

    task automatic feed_wide_record(int fields);
        for (int f = 0; f < fields; f++) begin
            feed(pick_plain(), 1'b0);
            if (f < fields - 1)
                feed(CH_COMMA, 1'b0);
        end
        feed(CH_LF, 1'b0);
    endtask

    initial begin
        #(200_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int tok_i;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        rx_hold_req = 1'b0;
        mismatches  = 0;
        bytes_fed   = 0;
        tok_i       = 0;
        tx_idle_pct = 14;
        rx_idle_pct = 83;
        clear_scan();
        sc_expected = 9'd1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_rows[r]) begin
            if (opening_rows[r].listed < 0)
                feed(opening_rows[r].data, opening_rows[r].eoi);
            else begin
                void'(scan_byte(opening_rows[r].data, opening_rows[r].eoi));
                repeat (opening_rows[r].listed) begin
                    tokens_due.push_back(opening_tokens[tok_i]);
                    tok_i++;
                end
                offer_byte(opening_rows[r].data, opening_rows[r].eoi);
            end
        end

        set_expected_fields(9'd2);
        run_records(100);
        // stall the result side while bytes keep coming
        rx_hold_req = 1'b1;
        run_records(100);
        set_expected_fields(9'd0);
        run_records(90);

        tx_idle_pct = 83;
        rx_idle_pct = 14;
        set_expected_fields(9'd511);
        run_records(110);
        set_expected_fields(9'd3);
        run_records(110);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_expected_fields(9'd256);
        feed_wide_record(258);
        set_expected_fields(9'd1);
        run_records(50);
        await_drain();
        run_records(50);

        await_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
